// File: sv/tspc_pkg.sv
// shared types and constants for the strip plane clipper
package tspc_pkg;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COLOUR_BITS = 16;
  localparam int T_BITS = 16;
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic signed [31:0] tex_w;
    logic [15:0] col_r;
    logic [15:0] col_g;
    logic [15:0] col_b;
    logic [15:0] col_a;
  } vtx_t;

  typedef struct packed {
    vtx_t v0;
    vtx_t v1;
    vtx_t v2;
  } tri_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_DIST, BK_EDGE, BK_DIV, BK_LERP, BK_EMIT
  } bk_state_t;

  localparam logic [2:0] REG_PX = 3'd0;
  localparam logic [2:0] REG_PY = 3'd1;
  localparam logic [2:0] REG_PZ = 3'd2;
  localparam logic [2:0] REG_NX = 3'd3;
  localparam logic [2:0] REG_NY = 3'd4;
  localparam logic [2:0] REG_NZ = 3'd5;
endpackage

// File: sv/tspc_if.sv
// valid/ready channel carrying vertex payloads
interface tspc_vtx_if;
  logic valid;
  logic ready;
  tspc_pkg::vtx_t data;
  logic flag;
  modport source (output valid, output data, output flag, input ready);
  modport sink (input valid, input data, input flag, output ready);
endinterface

// File: sv/tspc_front.sv
// front end: strip tracking, triangle assembly and queue
module tspc_front #(
  parameter int COLOUR_BITS = tspc_pkg::COLOUR_BITS
) (
  input  logic clk,
  input  logic rst_n,
  tspc_vtx_if.sink in_ch,
  output logic q_valid,
  output tspc_pkg::tri_t q_tri,
  input  logic q_pop
);
  tspc_pkg::vtx_t held0_r, held1_r, nv;
  logic [1:0] fill_r;
  logic odd_r;
  tspc_pkg::tri_t q_r [tspc_pkg::QDEPTH];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic acc, push;
  logic [1:0] fill_eff;
  logic odd_eff;
  localparam logic [15:0] CMASK = 16'((32'd1 << COLOUR_BITS) - 1);

  // mask colours to configured width
  always_comb begin
    nv = in_ch.data;
    nv.col_r = in_ch.data.col_r & CMASK;
    nv.col_g = in_ch.data.col_g & CMASK;
    nv.col_b = in_ch.data.col_b & CMASK;
    nv.col_a = in_ch.data.col_a & CMASK;
  end

  assign in_ch.ready = (cnt_r != 2'(tspc_pkg::QDEPTH));
  assign acc = in_ch.valid && in_ch.ready;
  assign fill_eff = in_ch.flag ? 2'd0 : fill_r;
  assign odd_eff = in_ch.flag ? 1'b0 : odd_r;
  assign push = acc && (fill_eff == 2'd2);

  // strip state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 2'd0;
      odd_r <= 1'b0;
    end else if (acc) begin
      if (fill_eff < 2'd2) begin
        fill_r <= fill_eff + 2'd1;
        odd_r <= odd_eff;
      end else begin
        odd_r <= ~odd_eff;
      end
    end
  end

  // held vertices
  always_ff @(posedge clk) begin
    if (acc) begin
      if (fill_eff == 2'd0) held0_r <= nv;
      else if (fill_eff == 2'd1) held1_r <= nv;
      else begin
        held0_r <= held1_r;
        held1_r <= nv;
      end
    end
  end

  // triangle queue
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r].v0 <= held0_r;
      q_r[wp_r].v1 <= odd_eff ? nv : held1_r;
      q_r[wp_r].v2 <= odd_eff ? held1_r : nv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_tri = q_r[rp_r];
endmodule

// File: sv/tspc_back.sv
// back end: plane distances, edge walk, division, lerp and emit
module tspc_back (
  input  logic clk,
  input  logic rst_n,
  input  logic signed [31:0] px, py, pz,
  input  logic signed [17:0] nx, ny, nz,
  input  logic q_valid,
  input  tspc_pkg::tri_t q_tri,
  output logic q_pop,
  tspc_vtx_if.source out_ch
);
  tspc_pkg::bk_state_t st_r, st_nxt;
  tspc_pkg::vtx_t v_r [3];
  tspc_pkg::vtx_t poly_r [4];
  logic signed [51:0] d_r [3];
  logic [1:0] k_r;        // distance index / edge index
  logic [1:0] axis_r;     // product axis for distance
  logic signed [51:0] acc_r;
  logic [2:0] n_r;
  logic [2:0] e_r;        // emit index
  // divider
  logic [52:0] rem_r, den_r;
  logic [15:0] q_r;
  logic [4:0] dc_r;
  logic [3:0] lc_r;       // lerp field index
  logic tail_r;           // append vertex j after crossing
  logic [1:0] ei_r, ej_r;
  tspc_pkg::vtx_t xv_r;
  logic [1:0] idx;

  // one multiply per cycle for the distance
  logic signed [32:0] diff;
  logic signed [17:0] nsel;
  logic signed [51:0] prod;
  always_comb begin
    case (axis_r)
      2'd0: begin diff = 33'(v_r[k_r].pos_x) - 33'(px); nsel = nx; end
      2'd1: begin diff = 33'(v_r[k_r].pos_y) - 33'(py); nsel = ny; end
      default: begin diff = 33'(v_r[k_r].pos_z) - 33'(pz); nsel = nz; end
    endcase
    prod = 52'(diff) * 52'(nsel);
  end

  // lerp operand select, one field per cycle
  logic signed [32:0] la, lb;
  logic signed [33:0] ldif;
  logic signed [50:0] lprod;
  logic signed [32:0] lres;
  tspc_pkg::vtx_t va, vb;
  assign va = v_r[ei_r];
  assign vb = v_r[ej_r];
  always_comb begin
    case (lc_r)
      4'd0: begin la = 33'(va.pos_x); lb = 33'(vb.pos_x); end
      4'd1: begin la = 33'(va.pos_y); lb = 33'(vb.pos_y); end
      4'd2: begin la = 33'(va.pos_z); lb = 33'(vb.pos_z); end
      4'd3: begin la = 33'(va.tex_u); lb = 33'(vb.tex_u); end
      4'd4: begin la = 33'(va.tex_v); lb = 33'(vb.tex_v); end
      4'd5: begin la = 33'(va.tex_w); lb = 33'(vb.tex_w); end
      4'd6: begin la = 33'({1'b0, va.col_r}); lb = 33'({1'b0, vb.col_r}); end
      4'd7: begin la = 33'({1'b0, va.col_g}); lb = 33'({1'b0, vb.col_g}); end
      4'd8: begin la = 33'({1'b0, va.col_b}); lb = 33'({1'b0, vb.col_b}); end
      default: begin la = 33'({1'b0, va.col_a}); lb = 33'({1'b0, vb.col_a}); end
    endcase
    ldif = 34'(lb) - 34'(la);
    lprod = 51'(ldif) * $signed({35'd0, q_r});
    // arithmetic shift floors toward minus infinity
    lres = la + 33'(lprod >>> tspc_pkg::T_BITS);
  end

  logic in_i, in_j;
  assign in_i = !d_r[ei_r][51];
  assign in_j = !d_r[ej_r][51];
  logic [52:0] ad_i, ad_d;
  logic signed [52:0] dd;
  always_comb begin
    dd = 53'(d_r[ei_r]) - 53'(d_r[ej_r]);
    ad_i = d_r[ei_r][51] ? 53'(-53'(d_r[ei_r])) : 53'(d_r[ei_r]);
    ad_d = dd[52] ? 53'(-dd) : 53'(dd);
  end

  // emit order of polygon points
  always_comb begin
    case (e_r)
      3'd3: idx = 2'd0;
      3'd4: idx = 2'd2;
      3'd5: idx = 2'd3;
      default: idx = e_r[1:0];
    endcase
  end

  logic ovalid_r;
  tspc_pkg::vtx_t odata_r;
  logic olast_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;
  assign out_ch.flag = olast_r;
  logic ofree;
  assign ofree = !ovalid_r || out_ch.ready;

  always_comb begin
    st_nxt = st_r;
    q_pop = 1'b0;
    case (st_r)
      tspc_pkg::BK_IDLE: if (q_valid) begin st_nxt = tspc_pkg::BK_DIST; q_pop = 1'b1; end
      tspc_pkg::BK_DIST: if (k_r == 2'd2 && axis_r == 2'd2) st_nxt = tspc_pkg::BK_EDGE;
      tspc_pkg::BK_EDGE: begin
        if (tail_r) st_nxt = tspc_pkg::BK_EDGE;
        else if (k_r == 2'd3) st_nxt = (n_r == 3'd3 || n_r == 3'd4) ?
            tspc_pkg::BK_EMIT : tspc_pkg::BK_IDLE;
        else if (in_i != in_j) st_nxt = tspc_pkg::BK_DIV;
      end
      tspc_pkg::BK_DIV: if (dc_r == 5'd16) st_nxt = tspc_pkg::BK_LERP;
      tspc_pkg::BK_LERP: if (lc_r == 4'd9) st_nxt = tspc_pkg::BK_EDGE;
      tspc_pkg::BK_EMIT: if (ofree && ((n_r == 3'd3 && e_r == 3'd2) || e_r == 3'd5))
        st_nxt = tspc_pkg::BK_IDLE;
      default: st_nxt = tspc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= tspc_pkg::BK_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      if (st_r == tspc_pkg::BK_EMIT && ofree) begin
        ovalid_r <= 1'b1;
        odata_r <= poly_r[idx];
        olast_r <= (n_r == 3'd3) ? (e_r == 3'd2) : (e_r == 3'd5);
        e_r <= e_r + 3'd1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
    case (st_r)
      tspc_pkg::BK_IDLE: begin
        v_r[0] <= q_tri.v0; v_r[1] <= q_tri.v1; v_r[2] <= q_tri.v2;
        k_r <= 2'd0; axis_r <= 2'd0; acc_r <= '0; n_r <= 3'd0; e_r <= 3'd0;
        tail_r <= 1'b0;
      end
      tspc_pkg::BK_DIST: begin
        if (axis_r == 2'd2) begin
          d_r[k_r] <= acc_r + prod;
          acc_r <= '0;
          axis_r <= 2'd0;
          if (k_r == 2'd2) begin
            k_r <= 2'd0; ei_r <= 2'd0; ej_r <= 2'd1;
          end else k_r <= k_r + 2'd1;
        end else begin
          acc_r <= acc_r + prod;
          axis_r <= axis_r + 2'd1;
        end
      end
      tspc_pkg::BK_EDGE: begin
        if (tail_r) begin
          poly_r[n_r[1:0]] <= v_r[ej_r];
          n_r <= n_r + 3'd1;
          tail_r <= 1'b0;
          k_r <= k_r + 2'd1;
          ei_r <= ej_r;
          ej_r <= (ej_r == 2'd2) ? 2'd0 : ej_r + 2'd1;
        end else if (k_r != 2'd3) begin
          if (in_i != in_j) begin
            rem_r <= ad_i; den_r <= ad_d; q_r <= '0; dc_r <= 5'd0;
          end else begin
            if (in_i) begin
              poly_r[n_r[1:0]] <= v_r[ej_r];
              n_r <= n_r + 3'd1;
            end
            k_r <= k_r + 2'd1;
            ei_r <= ej_r;
            ej_r <= (ej_r == 2'd2) ? 2'd0 : ej_r + 2'd1;
          end
        end
      end
      tspc_pkg::BK_DIV: begin
        // restoring division, one quotient bit per cycle
        if (dc_r == 5'd0 && rem_r >= den_r) begin
          q_r <= 16'hFFFF;
          dc_r <= 5'd16;
        end else if (dc_r != 5'd16) begin
          if ({rem_r[51:0], 1'b0} >= den_r) begin
            rem_r <= {rem_r[51:0], 1'b0} - den_r;
            q_r <= {q_r[14:0], 1'b1};
          end else begin
            rem_r <= {rem_r[51:0], 1'b0};
            q_r <= {q_r[14:0], 1'b0};
          end
          dc_r <= dc_r + 5'd1;
        end
        lc_r <= 4'd0;
      end
      tspc_pkg::BK_LERP: begin
        case (lc_r)
          4'd0: xv_r.pos_x <= lres[31:0];
          4'd1: xv_r.pos_y <= lres[31:0];
          4'd2: xv_r.pos_z <= lres[31:0];
          4'd3: xv_r.tex_u <= lres[31:0];
          4'd4: xv_r.tex_v <= lres[31:0];
          4'd5: xv_r.tex_w <= lres[31:0];
          4'd6: xv_r.col_r <= lres[15:0];
          4'd7: xv_r.col_g <= lres[15:0];
          4'd8: xv_r.col_b <= lres[15:0];
          default: xv_r.col_a <= lres[15:0];
        endcase
        if (lc_r == 4'd9) begin
          poly_r[n_r[1:0]] <= '{pos_x: xv_r.pos_x, pos_y: xv_r.pos_y, pos_z: xv_r.pos_z,
                               tex_u: xv_r.tex_u, tex_v: xv_r.tex_v, tex_w: xv_r.tex_w,
                               col_r: xv_r.col_r, col_g: xv_r.col_g, col_b: xv_r.col_b,
                               col_a: lres[15:0]};
          n_r <= n_r + 3'd1;
          if (in_j) tail_r <= 1'b1;
          else begin
            k_r <= k_r + 2'd1;
            ei_r <= ej_r;
            ej_r <= (ej_r == 2'd2) ? 2'd0 : ej_r + 2'd1;
          end
        end else lc_r <= lc_r + 4'd1;
      end
      default: ;
    endcase
  end
endmodule

// File: sv/triangle_strip_plane_clipper.sv
// top level: register port, front end, back end
// Clips a triangle strip against one plane, one vertex per transfer. The first two vertices
// of a strip give no output; each later vertex yields 0, 3 or 6 vertices, the last flagged
// by out_ch.flag. The front end keeps the strip and queues up to two triangles; the back
// end computes three plane distances with one multiplier, walks the edges, and per
// crossing edge runs a bit-serial divider and a lerp unit, then emits one vertex per
// cycle while out_ch is ready. Registers: plane point x/y/z, normal x/y/z at 4*i.
module triangle_strip_plane_clipper #(
  parameter int COLOUR_BITS = tspc_pkg::COLOUR_BITS
) (
  input  logic clk,
  input  logic rst_n,
  tspc_vtx_if.sink in_ch,
  tspc_vtx_if.source out_ch,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [4:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [17:0] nx_r, ny_r, nz_r;
  logic q_valid, q_pop;
  tspc_pkg::tri_t q_tri;
  logic [2:0] ridx;

  assign cfg_pready = 1'b1;
  assign ridx = cfg_paddr[4:2];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= '0; py_r <= '0; pz_r <= '0;
      nx_r <= '0; ny_r <= '0; nz_r <= -18'sd65536;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (ridx)
        tspc_pkg::REG_PX: px_r <= cfg_pwdata;
        tspc_pkg::REG_PY: py_r <= cfg_pwdata;
        tspc_pkg::REG_PZ: pz_r <= cfg_pwdata;
        tspc_pkg::REG_NX: nx_r <= cfg_pwdata[17:0];
        tspc_pkg::REG_NY: ny_r <= cfg_pwdata[17:0];
        tspc_pkg::REG_NZ: nz_r <= cfg_pwdata[17:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (ridx)
      tspc_pkg::REG_PX: cfg_prdata = px_r;
      tspc_pkg::REG_PY: cfg_prdata = py_r;
      tspc_pkg::REG_PZ: cfg_prdata = pz_r;
      tspc_pkg::REG_NX: cfg_prdata = 32'(nx_r);
      tspc_pkg::REG_NY: cfg_prdata = 32'(ny_r);
      tspc_pkg::REG_NZ: cfg_prdata = 32'(nz_r);
      default: cfg_prdata = '0;
    endcase
  end

  tspc_front #(.COLOUR_BITS(COLOUR_BITS)) u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_tri, .q_pop
  );

  tspc_back u_back (
    .clk, .rst_n, .px(px_r), .py(py_r), .pz(pz_r), .nx(nx_r), .ny(ny_r), .nz(nz_r),
    .q_valid, .q_tri, .q_pop, .out_ch
  );
endmodule
